// ===== hdl/jssd_pkg.sv =====
// Package for the job-shop schedule decoder.
// Holds sizes, operation and register codes and the issue-stage struct.
// No dependencies.
package jssd_pkg;

  localparam int MAX_JOBS      = 16;
  localparam int MAX_MACHINES  = 16;
  localparam int DURATION_BITS = 16;

  localparam int JOB_W       = 4;
  localparam int POS_W       = 4;
  localparam int MACH_W      = 4;
  localparam int DUR_W       = 16;
  localparam int TIME_W      = 24;
  localparam int CNT_W       = 5;
  localparam int CFG_W       = 5;
  localparam int CFG_INDEX_W = 1;

  localparam int TABLE_DEPTH = MAX_JOBS * MAX_MACHINES;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int JIDX_W      = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int SLOT_W      = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int ENTRY_W     = MACH_W + DURATION_BITS;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_JOBS     = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NUM_MACHINES = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [JOB_W-1:0] job;
    logic [POS_W-1:0] pos;
    logic             error;
    logic             last;
  } issue_t;

endpackage

// ===== hdl/jssd_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module jssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/jssd_seq.sv =====
// Issue stage: configuration registers, per-job operation counters,
// error check and operation-table addressing. Uses jssd_pkg.
module jssd_seq (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [jssd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [jssd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                             accept,
  input  logic                             op,
  input  logic [jssd_pkg::JOB_W-1:0]       job,
  input  logic                             last,
  input  logic                             fire,
  output logic                             rd_en,
  output logic [jssd_pkg::ADDR_W-1:0]      rd_addr,
  output jssd_pkg::issue_t                 issue
);

  logic [jssd_pkg::CFG_W-1:0] num_jobs;
  logic [jssd_pkg::CFG_W-1:0] num_machines;
  logic [jssd_pkg::CNT_W-1:0] next_op [jssd_pkg::MAX_JOBS];

  logic [jssd_pkg::CFG_W-1:0]  nj;
  logic [jssd_pkg::CFG_W-1:0]  nm;
  logic                        in_range;
  logic [jssd_pkg::JIDX_W-1:0] jidx;
  logic [jssd_pkg::CNT_W-1:0]  cur;
  logic                        bad;
  logic [jssd_pkg::POS_W-1:0]  pos;
  logic                        sched;

  always_comb begin
    nj = (num_jobs > jssd_pkg::CFG_W'(jssd_pkg::MAX_JOBS)) ?
         jssd_pkg::CFG_W'(jssd_pkg::MAX_JOBS) : num_jobs;
    nm = (num_machines > jssd_pkg::CFG_W'(jssd_pkg::MAX_MACHINES)) ?
         jssd_pkg::CFG_W'(jssd_pkg::MAX_MACHINES) : num_machines;
    in_range = ({1'b0, job} < (jssd_pkg::JOB_W + 1)'(jssd_pkg::MAX_JOBS));
    jidx     = jssd_pkg::JIDX_W'(job);
    cur      = in_range ? next_op[jidx] : '0;
    bad      = ({1'b0, job} >= jssd_pkg::CFG_W'(nj)) || (cur >= nm);
    pos      = jssd_pkg::POS_W'(cur);
    sched    = accept && (op == jssd_pkg::OP_SCHED);
    rd_en    = sched;
    rd_addr  = jssd_pkg::ADDR_W'(jssd_pkg::ADDR_W'(jidx) *
               jssd_pkg::ADDR_W'(jssd_pkg::MAX_MACHINES) + jssd_pkg::ADDR_W'(pos));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_jobs     <= jssd_pkg::CFG_W'(jssd_pkg::MAX_JOBS);
      num_machines <= jssd_pkg::CFG_W'(jssd_pkg::MAX_MACHINES);
      for (int i = 0; i < jssd_pkg::MAX_JOBS; i++) begin
        next_op[i] <= '0;
      end
      issue.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          jssd_pkg::CFG_NUM_JOBS:     num_jobs     <= cfg_data;
          jssd_pkg::CFG_NUM_MACHINES: num_machines <= cfg_data;
          default: ;
        endcase
      end
      if (sched) begin
        if (last) begin
          for (int i = 0; i < jssd_pkg::MAX_JOBS; i++) begin
            next_op[i] <= '0;
          end
        end else if (!bad) begin
          next_op[jidx] <= cur + 1'b1;
        end
        issue.valid <= 1'b1;
      end else if (fire) begin
        issue.valid <= 1'b0;
      end
    end
    if (sched) begin
      issue.job   <= job;
      issue.pos   <= pos;
      issue.error <= bad;
      issue.last  <= last;
    end
  end

endmodule

// ===== hdl/jssd_time.sv =====
// Timing stage: job-ready and machine-free stores, start/finish arithmetic,
// running makespan and the result register. Uses jssd_pkg.
module jssd_time (
  input  logic                                clk,
  input  logic                                rst,
  input  jssd_pkg::issue_t                    issue,
  input  logic [jssd_pkg::ENTRY_W-1:0]        entry,
  input  logic                                res_stall,
  output logic                                fire,
  output logic                                res_valid,
  output logic [jssd_pkg::JOB_W-1:0]          out_job,
  output logic [jssd_pkg::POS_W-1:0]          out_position,
  output logic [jssd_pkg::MACH_W-1:0]         out_machine,
  output logic [jssd_pkg::TIME_W-1:0]         start_time,
  output logic [jssd_pkg::TIME_W-1:0]         finish_time,
  output logic [jssd_pkg::TIME_W-1:0]         makespan,
  output logic                                done_res,
  output logic                                error
);

  logic [jssd_pkg::TIME_W-1:0] job_ready [jssd_pkg::MAX_JOBS];
  logic [jssd_pkg::TIME_W-1:0] mach_free [jssd_pkg::MAX_MACHINES];
  logic [jssd_pkg::TIME_W-1:0] span;

  logic [jssd_pkg::MACH_W-1:0]        mach;
  logic [jssd_pkg::DURATION_BITS-1:0] dur;
  logic [jssd_pkg::SLOT_W-1:0]        slot;
  logic [jssd_pkg::JIDX_W-1:0]        jidx;
  logic [jssd_pkg::TIME_W-1:0]        jr;
  logic [jssd_pkg::TIME_W-1:0]        mf;
  logic [jssd_pkg::TIME_W-1:0]        start;
  logic [jssd_pkg::TIME_W:0]          sum;
  logic [jssd_pkg::TIME_W-1:0]        finish;
  logic [jssd_pkg::TIME_W-1:0]        span_next;

  always_comb begin
    mach      = entry[jssd_pkg::ENTRY_W-1 -: jssd_pkg::MACH_W];
    dur       = entry[jssd_pkg::DURATION_BITS-1:0];
    slot      = jssd_pkg::SLOT_W'(mach % jssd_pkg::MAX_MACHINES);
    jidx      = jssd_pkg::JIDX_W'(issue.job);
    jr        = job_ready[jidx];
    mf        = mach_free[slot];
    start     = (mf > jr) ? mf : jr;
    sum       = {1'b0, start} + (jssd_pkg::TIME_W + 1)'(dur);
    finish    = sum[jssd_pkg::TIME_W] ? '1 : sum[jssd_pkg::TIME_W-1:0];
    span_next = (finish > span) ? finish : span;
    fire      = issue.valid && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < jssd_pkg::MAX_JOBS; i++) begin
        job_ready[i] <= '0;
      end
      for (int i = 0; i < jssd_pkg::MAX_MACHINES; i++) begin
        mach_free[i] <= '0;
      end
      span      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (fire) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (fire && issue.last) begin
        for (int i = 0; i < jssd_pkg::MAX_JOBS; i++) begin
          job_ready[i] <= '0;
        end
        for (int i = 0; i < jssd_pkg::MAX_MACHINES; i++) begin
          mach_free[i] <= '0;
        end
        span <= '0;
      end else if (fire && !issue.error) begin
        job_ready[jidx] <= finish;
        mach_free[slot] <= finish;
        span            <= span_next;
      end
    end
    if (fire) begin
      out_job      <= issue.job;
      out_position <= issue.pos;
      done_res     <= issue.last;
      error        <= issue.error;
      if (issue.error) begin
        out_machine <= '0;
        start_time  <= '0;
        finish_time <= '0;
        makespan    <= span;
      end else begin
        out_machine <= mach;
        start_time  <= start;
        finish_time <= finish;
        makespan    <= span_next;
      end
    end
  end

endmodule

// ===== hdl/job_shop_schedule_decoder.sv =====
// Job-shop schedule decoder: repetition-vector items to a semi-active schedule.
// Each schedule item's result passes the issue register and then the result register.
// Throughput: one item per cycle; the issue stage reads the table, the next does the
// max, the add and the time-store write back; a stalled result fills both stages.
// Reset clears counters, time stores, valid flags; sizes go to maximum; not the table.
// Uses jssd_pkg, jssd_ram, jssd_seq and jssd_time.
module job_shop_schedule_decoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [jssd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [jssd_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                op,
  input  logic [jssd_pkg::JOB_W-1:0]          job,
  input  logic [jssd_pkg::POS_W-1:0]          position,
  input  logic [jssd_pkg::MACH_W-1:0]         machine,
  input  logic [jssd_pkg::DUR_W-1:0]          duration,
  input  logic                                last,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [jssd_pkg::JOB_W-1:0]          out_job,
  output logic [jssd_pkg::POS_W-1:0]          out_position,
  output logic [jssd_pkg::MACH_W-1:0]         out_machine,
  output logic [jssd_pkg::TIME_W-1:0]         start_time,
  output logic [jssd_pkg::TIME_W-1:0]         finish_time,
  output logic [jssd_pkg::TIME_W-1:0]         makespan,
  output logic                                done_res,
  output logic                                error
);

  jssd_pkg::issue_t                 issue;
  logic                             fire;
  logic                             accept;
  logic                             rd_en;
  logic [jssd_pkg::ADDR_W-1:0]      rd_addr;
  logic [jssd_pkg::ENTRY_W-1:0]     entry;
  logic                             wr_en;
  logic [jssd_pkg::ADDR_W-1:0]      wr_addr;
  logic [jssd_pkg::ENTRY_W-1:0]     wr_data;

  always_comb begin
    item_stall = issue.valid && !fire;
    accept     = item_valid && !item_stall;
    wr_en      = accept && (op == jssd_pkg::OP_LOAD) &&
                 ({1'b0, job} < (jssd_pkg::JOB_W + 1)'(jssd_pkg::MAX_JOBS)) &&
                 ({1'b0, position} < (jssd_pkg::POS_W + 1)'(jssd_pkg::MAX_MACHINES));
    wr_addr    = jssd_pkg::ADDR_W'(jssd_pkg::ADDR_W'(job) *
                 jssd_pkg::ADDR_W'(jssd_pkg::MAX_MACHINES) + jssd_pkg::ADDR_W'(position));
    wr_data    = {machine, duration[jssd_pkg::DURATION_BITS-1:0]};
  end

  jssd_ram #(
    .WIDTH(jssd_pkg::ENTRY_W),
    .DEPTH(jssd_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (entry)
  );

  jssd_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .op        (op),
    .job       (job),
    .last      (last),
    .fire      (fire),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .issue     (issue)
  );

  jssd_time u_time (
    .clk          (clk),
    .rst          (rst),
    .issue        (issue),
    .entry        (entry),
    .res_stall    (res_stall),
    .fire         (fire),
    .res_valid    (res_valid),
    .out_job      (out_job),
    .out_position (out_position),
    .out_machine  (out_machine),
    .start_time   (start_time),
    .finish_time  (finish_time),
    .makespan     (makespan),
    .done_res     (done_res),
    .error        (error)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for job_shop_schedule_decoder: table loads and repetition-vector
// sequences under random idling, checked against a scheduling tracker class.
// Depends on jssd_pkg and the decoder RTL only.

typedef struct {
  bit [jssd_pkg::JOB_W-1:0]  job;
  bit [jssd_pkg::POS_W-1:0]  pos;
  bit [jssd_pkg::MACH_W-1:0] mach;
  bit [jssd_pkg::TIME_W-1:0] start;
  bit [jssd_pkg::TIME_W-1:0] finish;
  bit [jssd_pkg::TIME_W-1:0] span;
  bit                        done;
  bit                        err;
} sched_op_t;

class schedule_tracker;
  bit [jssd_pkg::CFG_W-1:0]  jobs_reg = jssd_pkg::CFG_W'(jssd_pkg::MAX_JOBS);
  bit [jssd_pkg::CFG_W-1:0]  ops_reg  = jssd_pkg::CFG_W'(jssd_pkg::MAX_MACHINES);
  bit [jssd_pkg::MACH_W-1:0] mach_tab [jssd_pkg::TABLE_DEPTH];
  bit [jssd_pkg::DUR_W-1:0]  dur_tab  [jssd_pkg::TABLE_DEPTH];
  bit                        loaded   [jssd_pkg::TABLE_DEPTH];
  bit [jssd_pkg::CNT_W-1:0]  next_op  [jssd_pkg::MAX_JOBS];
  bit [jssd_pkg::TIME_W-1:0] job_ready[jssd_pkg::MAX_JOBS];
  bit [jssd_pkg::TIME_W-1:0] mach_free[jssd_pkg::MAX_MACHINES];
  bit [jssd_pkg::TIME_W-1:0] span;
  sched_op_t                 due_ops[$];
  int                        fails;

  function int jobs_eff();
    return (jobs_reg > jssd_pkg::MAX_JOBS) ? jssd_pkg::MAX_JOBS : int'(jobs_reg);
  endfunction

  function int ops_eff();
    return (ops_reg > jssd_pkg::MAX_MACHINES) ? jssd_pkg::MAX_MACHINES : int'(ops_reg);
  endfunction

  function void write_reg(bit [jssd_pkg::CFG_INDEX_W-1:0] idx,
                          bit [jssd_pkg::CFG_W-1:0] data);
    if (idx == jssd_pkg::CFG_NUM_JOBS) jobs_reg = data;
    else if (idx == jssd_pkg::CFG_NUM_MACHINES) ops_reg = data;
  endfunction

  function void accept_item(bit o, bit [jssd_pkg::JOB_W-1:0] j,
                            bit [jssd_pkg::POS_W-1:0] p,
                            bit [jssd_pkg::MACH_W-1:0] m,
                            bit [jssd_pkg::DUR_W-1:0] d, bit l);
    sched_op_t                 r;
    int                        idx;
    bit [jssd_pkg::SLOT_W-1:0] slot;
    bit [jssd_pkg::TIME_W:0]   sum;
    bit [jssd_pkg::TIME_W-1:0] st;
    bit [jssd_pkg::TIME_W-1:0] fin;
    if (o == jssd_pkg::OP_LOAD) begin
      idx = j * jssd_pkg::MAX_MACHINES + p;
      mach_tab[idx] = m;
      dur_tab[idx]  = d;
      loaded[idx]   = 1'b1;
      return;
    end
    r.job  = j;
    r.done = l;
    if (j >= jobs_eff() || next_op[j] >= ops_eff()) begin
      r.pos    = next_op[j][jssd_pkg::POS_W-1:0];
      r.mach   = '0;
      r.start  = '0;
      r.finish = '0;
      r.span   = span;
      r.err    = 1'b1;
    end else begin
      idx  = j * jssd_pkg::MAX_MACHINES + next_op[j];
      slot = jssd_pkg::SLOT_W'(mach_tab[idx] % jssd_pkg::MAX_MACHINES);
      st   = (job_ready[j] > mach_free[slot]) ? job_ready[j] : mach_free[slot];
      sum  = {1'b0, st} + (jssd_pkg::TIME_W + 1)'(dur_tab[idx]);
      fin  = sum[jssd_pkg::TIME_W] ? '1 : sum[jssd_pkg::TIME_W-1:0];
      r.pos    = next_op[j][jssd_pkg::POS_W-1:0];
      r.mach   = mach_tab[idx];
      r.start  = st;
      r.finish = fin;
      job_ready[j]    = fin;
      mach_free[slot] = fin;
      next_op[j]      = next_op[j] + 1'b1;
      if (fin > span) span = fin;
      r.span = span;
      r.err  = 1'b0;
    end
    due_ops = {due_ops, r};
    if (l) begin
      next_op   = '{default: '0};
      job_ready = '{default: '0};
      mach_free = '{default: '0};
      span      = '0;
    end
  endfunction

  function void match(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endfunction

  function void compare_op(sched_op_t got);
    sched_op_t want;
    if (due_ops.size() == 0) begin
      $error("result with no item pending: job %0d", got.job);
      fails++;
      return;
    end
    want = due_ops.pop_front();
    match("out_job", want.job, got.job);
    match("out_position", want.pos, got.pos);
    match("out_machine", want.mach, got.mach);
    match("start_time", want.start, got.start);
    match("finish_time", want.finish, got.finish);
    match("makespan", want.span, got.span);
    match("done_res", want.done, got.done);
    match("error", want.err, got.err);
  endfunction
endclass

module tb;
  localparam int LIMIT = 400000;

  logic                             clk        = 1'b0;
  logic                             rst        = 1'b1;
  logic                             cfg_we     = 1'b0;
  logic [jssd_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [jssd_pkg::CFG_W-1:0]       cfg_data   = '0;
  logic                             item_valid = 1'b0;
  logic                             item_stall;
  logic                             op         = 1'b0;
  logic [jssd_pkg::JOB_W-1:0]       job        = '0;
  logic [jssd_pkg::POS_W-1:0]       position   = '0;
  logic [jssd_pkg::MACH_W-1:0]      machine    = '0;
  logic [jssd_pkg::DUR_W-1:0]       duration   = '0;
  logic                             last       = 1'b0;
  logic                             res_valid;
  logic                             res_stall  = 1'b0;
  logic [jssd_pkg::JOB_W-1:0]       out_job;
  logic [jssd_pkg::POS_W-1:0]       out_position;
  logic [jssd_pkg::MACH_W-1:0]      out_machine;
  logic [jssd_pkg::TIME_W-1:0]      start_time;
  logic [jssd_pkg::TIME_W-1:0]      finish_time;
  logic [jssd_pkg::TIME_W-1:0]      makespan;
  logic                             done_res;
  logic                             error;

  schedule_tracker tracker = new();
  int  cycles;
  int  items_sent;
  int  results_seen;
  int  seen_prev;
  int  hold_left;
  bit  paused;
  logic quiet;

  assign quiet = ((cycles / 150) % 4) == 0;

  job_shop_schedule_decoder uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .op(op), .job(job), .position(position), .machine(machine),
    .duration(duration), .last(last),
    .res_valid(res_valid), .res_stall(res_stall),
    .out_job(out_job), .out_position(out_position), .out_machine(out_machine),
    .start_time(start_time), .finish_time(finish_time), .makespan(makespan),
    .done_res(done_res), .error(error)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    sched_op_t got;
    if (!rst && res_valid && !res_stall) begin
      got.job    = out_job;
      got.pos    = out_position;
      got.mach   = out_machine;
      got.start  = start_time;
      got.finish = finish_time;
      got.span   = makespan;
      got.done   = done_res;
      got.err    = error;
      tracker.compare_op(got);
      results_seen++;
    end
  end

  // receiver: hold off after each item; one long hold to back the block up
  always @(negedge clk) begin
    if (results_seen != seen_prev) begin
      seen_prev = results_seen;
      if (results_seen == 150) hold_left = 120;
      else hold_left = quiet ? 0 : $urandom_range(0, 8);
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else begin
      res_stall <= 1'b0;
    end
  end

  function automatic bit [jssd_pkg::DUR_W-1:0] rand_dur();
    case ($urandom_range(0, 9))
      0: rand_dur = '0;
      1: rand_dur = '1;
      2: rand_dur = jssd_pkg::DUR_W'($urandom);
      default: rand_dur = jssd_pkg::DUR_W'($urandom_range(1, 20));
    endcase
  endfunction

  task automatic send(bit o, bit [jssd_pkg::JOB_W-1:0] j, bit [jssd_pkg::POS_W-1:0] p,
                      bit [jssd_pkg::MACH_W-1:0] m, bit [jssd_pkg::DUR_W-1:0] d, bit l);
    int gap;
    gap = (quiet || hold_left > 8) ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    op         <= o;
    job        <= j;
    position   <= p;
    machine    <= m;
    duration   <= d;
    last       <= l;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tracker.accept_item(o, j, p, m, d, l);
    items_sent++;
  endtask

  task automatic load_entry(int j, int p);
    send(jssd_pkg::OP_LOAD, jssd_pkg::JOB_W'(j), jssd_pkg::POS_W'(p),
         jssd_pkg::MACH_W'($urandom_range(0, 15)), rand_dur(), 1'($urandom_range(0, 1)));
  endtask

  // loads the entry first if the item would read one never written
  task automatic sched(int j, bit l);
    int p;
    p = tracker.next_op[j];
    if (j < tracker.jobs_eff() && p < tracker.ops_eff() &&
        !tracker.loaded[j * jssd_pkg::MAX_MACHINES + p])
      load_entry(j, p);
    send(jssd_pkg::OP_SCHED, jssd_pkg::JOB_W'(j), jssd_pkg::POS_W'($urandom_range(0, 15)),
         jssd_pkg::MACH_W'($urandom_range(0, 15)), jssd_pkg::DUR_W'($urandom), l);
  endtask

  task automatic drain(int extra);
    @(negedge clk);
    item_valid <= 1'b0;
    while (tracker.due_ops.size() > 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_reg(bit [jssd_pkg::CFG_INDEX_W-1:0] idx,
                           bit [jssd_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_size(int jv, int mv);
    drain(6);
    write_reg(jssd_pkg::CFG_NUM_JOBS, jssd_pkg::CFG_W'(jv));
    write_reg(jssd_pkg::CFG_NUM_MACHINES, jssd_pkg::CFG_W'(mv));
  endtask

  task automatic run_phase(int jv, int mv);
    int nje, nme, nseq, k, x, tmp, pick;
    int vec[$];
    bit trail;
    set_size(jv, mv);
    nje = tracker.jobs_eff();
    nme = tracker.ops_eff();
    for (int j = 0; j < nje; j++)
      for (int p = 0; p < nme; p++)
        if (!tracker.loaded[j * jssd_pkg::MAX_MACHINES + p] || $urandom_range(0, 1))
          load_entry(j, p);
    nseq = (nje * nme > 64) ? 1 : $urandom_range(1, 3);
    repeat (nseq) begin
      vec.delete();
      for (int j = 0; j < nje; j++) repeat (nme) vec = {vec, j};
      for (k = vec.size() - 1; k > 0; k--) begin
        x = $urandom_range(0, k);
        tmp = vec[k];
        vec[k] = vec[x];
        vec[x] = tmp;
      end
      if (vec.size() == 0) begin
        repeat (2) sched($urandom_range(0, 15), 1'b0);
        sched($urandom_range(0, 15), 1'b1);
        continue;
      end
      trail = ($urandom_range(0, 5) == 0);
      for (k = 0; k < vec.size(); k++) begin
        if (!paused && items_sent >= 300) begin
          paused = 1'b1;
          drain(0);
        end
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0, 2: sched($urandom_range(0, 15), $urandom_range(0, 15) == 0);
            1: load_entry($urandom_range(0, 15), $urandom_range(0, 15));
            default: begin
              pick = $urandom_range(0, 15);
              for (int j = 0; j < nje; j++)
                if (tracker.next_op[j] >= nme) pick = j;
              sched(pick, 1'b0);
            end
          endcase
        end
        sched(vec[k], (k == vec.size() - 1) && !trail);
      end
      if (trail) sched($urandom_range(0, 15), 1'b1);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    load_entry(0, 0);
    send(jssd_pkg::OP_LOAD, 4'd0, 4'd0, 4'd15, 16'hFFFF, 1'b1);
    send(jssd_pkg::OP_LOAD, 4'd0, 4'd1, 4'd0, 16'h0000, 1'b0);
    send(jssd_pkg::OP_LOAD, 4'd15, 4'd0, 4'd15, 16'h0001, 1'b0);
    send(jssd_pkg::OP_LOAD, 4'd15, 4'd1, 4'd0, 16'hFFFF, 1'b1);
    send(jssd_pkg::OP_LOAD, 4'd15, 4'd15, 4'd15, 16'hFFFF, 1'b0);
    send(jssd_pkg::OP_LOAD, 4'd0, 4'd15, 4'd0, 16'h8000, 1'b0);
    sched(0, 1'b0);
    sched(15, 1'b0);
    sched(0, 1'b0);
    sched(15, 1'b1);
    sched(0, 1'b0);
    sched(0, 1'b1);
    set_size(1, 2);
    sched(1, 1'b0);
    sched(0, 1'b0);
    sched(0, 1'b0);
    sched(0, 1'b0);
    sched(0, 1'b1);
    sched(0, 1'b1);
    set_size(0, 31);
    sched(0, 1'b1);
    sched(15, 1'b0);

    run_phase(31, 31);
    run_phase(1, 1);
    run_phase(16, 1);
    run_phase(1, 16);
    run_phase(0, 4);
    run_phase(4, 0);
    run_phase(17, 2);
    while (items_sent < 700) begin
      if ($urandom_range(0, 9) == 0) run_phase($urandom_range(0, 31), $urandom_range(0, 31));
      else run_phase($urandom_range(1, 6), $urandom_range(1, 6));
    end

    drain(8);
    if (tracker.fails == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/jssd_pkg.sv
hdl/jssd_ram.sv
hdl/jssd_seq.sv
hdl/jssd_time.sv
hdl/job_shop_schedule_decoder.sv
verif/tb.sv
